>>> design/mle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mle_pkg: shared types, constants and field arithmetic
// Widths of the payload fields, operation and register codes and the
// modular add/subtract/fold helpers for the prime 2^61-1.
// ----------------------------------------------------------------------------
package mle_pkg;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 61;
  localparam int LOG_W   = 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int DEF_MAX_LOG_ROWS = 5;
  localparam int DEF_MAX_LOG_COLS = 5;

  localparam logic [VALUE_W-1:0] FIELD_P = {VALUE_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ENTRY = 2'd0,
    OP_ROW   = 2'd1,
    OP_COL   = 2'd2,
    OP_EVAL  = 2'd3
  } op_e;

  // register select, taken from paddr bit 2
  localparam logic REG_LOG_ROWS = 1'b0;
  localparam logic REG_LOG_COLS = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // a + b mod P, both below P
  function automatic logic [VALUE_W-1:0] add_p(logic [VALUE_W-1:0] a,
                                               logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, FIELD_P}) s = s - {1'b0, FIELD_P};
    return s[VALUE_W-1:0];
  endfunction

  // a - b mod P, both below P
  function automatic logic [VALUE_W-1:0] sub_p(logic [VALUE_W-1:0] a,
                                               logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + {1'b0, FIELD_P} - {1'b0, b};
    return s[VALUE_W-1:0];
  endfunction

  // fold a 64-bit value down to its residue below P
  function automatic logic [VALUE_W-1:0] fold64(logic [63:0] x);
    logic [VALUE_W:0] t;
    t = {1'b0, x[VALUE_W-1:0]} + {{(VALUE_W-2){1'b0}}, x[63:VALUE_W]};
    if (t >= {1'b0, FIELD_P}) t = t - {1'b0, FIELD_P};
    return t[VALUE_W-1:0];
  endfunction

endpackage

>>> design/mle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mle_if: stream channels of the evaluator
// Input channel carries operation, index and value; output carries result.
// ----------------------------------------------------------------------------
interface mle_in_if;
  logic                         valid;
  logic                         ready;
  logic [mle_pkg::OP_W-1:0]     operation;
  logic [mle_pkg::INDEX_W-1:0]  index;
  logic [mle_pkg::VALUE_W-1:0]  value;

  modport source(output valid, operation, index, value, input ready);
  modport sink(input valid, operation, index, value, output ready);
endinterface

interface mle_out_if;
  logic                         valid;
  logic                         ready;
  logic [mle_pkg::VALUE_W-1:0]  result;

  modport source(output valid, result, input ready);
  modport sink(input valid, result, output ready);
endinterface

>>> design/mle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mle_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mle_ram #(
  parameter int WIDTH = 61,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/mle_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mle_mulmod: sequential multiplier modulo 2^61-1
// Four 31x31 partial products, one per cycle, each registered and then
// folded into the residue accumulator.
// ----------------------------------------------------------------------------
module mle_mulmod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mle_pkg::VALUE_W-1:0]  a_i,
  input  logic [mle_pkg::VALUE_W-1:0]  b_i,
  output logic [mle_pkg::VALUE_W-1:0]  result_o,
  output mle_pkg::mul_stat_t           stat_o
);
  import mle_pkg::*;

  localparam int HW = 31;

  logic [VALUE_W-1:0] a_q, b_q, acc_q;
  logic [1:0]         cnt_q, pk_q;
  logic               run_q, pv_q, done_q;
  logic [2*HW-1:0]    prod_q;
  logic [HW-1:0]      opx, opy;
  logic [63:0]        term;

  // operand halves for the current partial product
  always_comb begin
    opx = cnt_q[1] ? a_q[HW-1:0] : {1'b0, a_q[VALUE_W-1:HW]};
    opy = cnt_q[0] ? b_q[HW-1:0] : {1'b0, b_q[VALUE_W-1:HW]};
  end

  // weight each partial product: high*high by 2, cross terms by 2^31
  always_comb begin
    case (pk_q)
      2'd0:    term = {3'b0, prod_q[59:0], 1'b0};
      2'd1,
      2'd2:    term = {33'b0, prod_q[60:30]} + {3'b0, prod_q[29:0], 31'b0};
      default: term = {2'b0, prod_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      pk_q   <= '0;
    end else begin
      done_q <= pv_q && (pk_q == 2'd3);
      pv_q   <= run_q;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        pk_q  <= cnt_q;
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) run_q <= 1'b0;
      end
    end
  end

  // payload: operands, partial product, accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= fold64({3'b0, acc_q} + term);
    end
    if (run_q) prod_q <= {1'b0, opx} * {1'b0, opy};
  end

  assign result_o    = acc_q;
  assign stat_o.busy = run_q | pv_q | done_q;
  assign stat_o.done = done_q;

endmodule

>>> design/multilinear_extension_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilinear_extension_eval: matrix multilinear extension modulo 2^61-1
// Stores a matrix and a row/column point and evaluates the extension by
// folding the matrix one variable at a time.
// ----------------------------------------------------------------------------
// Load beats (entry, row coordinate, column coordinate) are taken one per
// cycle while the sequencer is idle. An evaluate folds the 2^L entries
// (L = rows log + cols log) one variable at a time, column bits first: each
// pair e0, e1 becomes e0 + c*(e1 - e0), written to a scratch RAM. A pair
// takes two reads of the single-read-port RAM, then the sequential modular
// multiplier at one 31x31 partial product per cycle; no input is taken
// during an evaluate. The result waits in an output register, and loads are
// taken while it waits.
// ----------------------------------------------------------------------------
module multilinear_extension_eval #(
  parameter int MAX_LOG_ROWS = mle_pkg::DEF_MAX_LOG_ROWS,
  parameter int MAX_LOG_COLS = mle_pkg::DEF_MAX_LOG_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mle_in_if.sink                        in_i,
  mle_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mle_pkg::PADDR_W-1:0]   paddr,
  input  logic [mle_pkg::PDATA_W-1:0]   pwdata,
  output logic [mle_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mle_pkg::*;

  localparam int AW   = MAX_LOG_ROWS + MAX_LOG_COLS;
  localparam int SAW  = (AW > 0) ? AW : 1;
  localparam int PW   = (AW > 1) ? AW - 1 : 1;
  localparam int STORE_DEPTH = 1 << AW;
  localparam int SCR_DEPTH   = 1 << PW;
  localparam int LW   = $clog2(AW + 1) > 0 ? $clog2(AW + 1) : 1;
  localparam int RLW  = $clog2(MAX_LOG_ROWS + 1) > 0 ? $clog2(MAX_LOG_ROWS + 1) : 1;
  localparam int CLW  = $clog2(MAX_LOG_COLS + 1) > 0 ? $clog2(MAX_LOG_COLS + 1) : 1;
  localparam int RPD  = (MAX_LOG_ROWS > 0) ? MAX_LOG_ROWS : 1;
  localparam int CPD  = (MAX_LOG_COLS > 0) ? MAX_LOG_COLS : 1;
  localparam int RIW  = (RPD > 1) ? $clog2(RPD) : 1;
  localparam int CIW  = (CPD > 1) ? $clog2(CPD) : 1;
  localparam int SHW  = LW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN0 = 3'd5;
  localparam logic [2:0] S_FIN1 = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [LW-1:0]      lv_q, lv_d;
  logic [PW-1:0]      pair_q, pair_d, lim_q, lim_d;
  logic               src_q, src_d;
  logic [VALUE_W-1:0] e0_q;
  logic [VALUE_W-1:0] sum_acc_q;
  logic               out_valid_q;
  logic [LOG_W-1:0]   log_rows_q, log_cols_q;
  logic [VALUE_W-1:0] rp_q [RPD];
  logic [VALUE_W-1:0] cp_q [CPD];

  logic               in_acc, cfg_we, rd_odd, rd_zero;
  logic [VALUE_W-1:0] in_val, mat_rdata, scr_rdata, src_rdata, coord, fold_val;
  logic [RLW-1:0]     lr_eff;
  logic [CLW-1:0]     lc_eff;
  logic [LW-1:0]      l_tot;
  logic [SHW-1:0]     lim_sh;
  logic               mat_we, scr_we, mul_start, out_load;
  logic [SAW-1:0]     mat_raddr;
  logic [PW-1:0]      scr_raddr;
  logic [VALUE_W-1:0] mul_res;
  mul_stat_t          mul_stat;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      REG_LOG_ROWS: prdata = {{(PDATA_W-LOG_W){1'b0}}, log_rows_q};
      default:      prdata = {{(PDATA_W-LOG_W){1'b0}}, log_cols_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_rows_q <= '0;
      log_cols_q <= '0;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_LOG_ROWS: log_rows_q <= pwdata[LOG_W-1:0];
        default:      log_cols_q <= pwdata[LOG_W-1:0];
      endcase
    end
  end

  // saturated sizes and total variable count
  always_comb begin
    lr_eff = (32'(log_rows_q) > MAX_LOG_ROWS) ? RLW'(MAX_LOG_ROWS) : RLW'(log_rows_q);
    lc_eff = (32'(log_cols_q) > MAX_LOG_COLS) ? CLW'(MAX_LOG_COLS) : CLW'(log_cols_q);
    l_tot  = LW'(lr_eff) + LW'(lc_eff);
    lim_sh = SHW'(PW) - SHW'(l_tot) + SHW'(1);
  end

  // input beat
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_val     = (in_i.value == FIELD_P) ? '0 : in_i.value;
  assign mat_we     = in_acc && (in_i.operation == OP_ENTRY) &&
                      (32'(in_i.index) < STORE_DEPTH);

  // coordinate registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.operation == OP_ROW) && (32'(in_i.index) < MAX_LOG_ROWS))
      rp_q[RIW'(in_i.index)] <= in_val;
    if (in_acc && (in_i.operation == OP_COL) && (32'(in_i.index) < MAX_LOG_COLS))
      cp_q[CIW'(in_i.index)] <= in_val;
  end

  // coordinate of the variable being folded, column bits first
  always_comb begin
    if (lv_q < LW'(lc_eff)) coord = cp_q[CIW'(lv_q)];
    else                    coord = rp_q[RIW'(lv_q - LW'(lc_eff))];
  end

  // read addressing of the two stores
  assign rd_odd    = (state_q == S_RD1);
  assign rd_zero   = (state_q == S_FIN0) || (state_q == S_FIN1);
  assign mat_raddr = rd_zero ? '0 : SAW'({pair_q, rd_odd});
  assign scr_raddr = rd_zero ? '0 : PW'({pair_q, rd_odd});
  assign src_rdata = src_q ? scr_rdata : mat_rdata;

  mle_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_matrix (
    .clk_i  (clk_i),
    .we_i   (mat_we),
    .waddr_i(SAW'(in_i.index)),
    .wdata_i(in_val),
    .raddr_i(mat_raddr),
    .rdata_o(mat_rdata)
  );

  mle_ram #(.WIDTH(VALUE_W), .DEPTH(SCR_DEPTH)) u_scratch (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(pair_q),
    .wdata_i(fold_val),
    .raddr_i(scr_raddr),
    .rdata_o(scr_rdata)
  );

  // fold arithmetic: e0 + c*(e1 - e0)
  assign mul_start = (state_q == S_CAP);
  assign fold_val  = add_p(e0_q, mul_res);
  assign scr_we    = (state_q == S_MUL) && mul_stat.done;

  mle_mulmod u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (sub_p(src_rdata, e0_q)),
    .b_i     (coord),
    .result_o(mul_res),
    .stat_o  (mul_stat)
  );

  // fold sequencer
  assign out_load = (state_q == S_FIN1) && (!out_valid_q || out_o.ready);
  always_comb begin
    state_d = state_q;
    lv_d    = lv_q;
    pair_d  = pair_q;
    lim_d   = lim_q;
    src_d   = src_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.operation == OP_EVAL)) begin
          lv_d   = '0;
          pair_d = '0;
          lim_d  = {PW{1'b1}} >> lim_sh;
          src_d  = 1'b0;
          state_d = (l_tot == '0) ? S_FIN0 : S_RD0;
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: state_d = S_CAP;
      S_CAP: state_d = S_MUL;
      S_MUL: begin
        if (mul_stat.done) begin
          if (pair_q == lim_q) begin
            src_d  = 1'b1;
            pair_d = '0;
            if (lv_q == l_tot - LW'(1)) begin
              state_d = S_FIN0;
            end else begin
              lv_d    = lv_q + LW'(1);
              lim_d   = lim_q >> 1;
              state_d = S_RD0;
            end
          end else begin
            pair_d  = pair_q + PW'(1);
            state_d = S_RD0;
          end
        end
      end
      S_FIN0: state_d = S_FIN1;
      S_FIN1: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lv_q        <= '0;
      pair_q      <= '0;
      lim_q       <= '0;
      src_q       <= 1'b0;
      out_valid_q <= 1'b0;
      sum_acc_q   <= '0;
    end else begin
      state_q <= state_d;
      lv_q    <= lv_d;
      pair_q  <= pair_d;
      lim_q   <= lim_d;
      src_q   <= src_d;
      if (out_load)                      out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;
      if (out_load)                      sum_acc_q   <= src_rdata;
    end
  end

  // first entry of the pair
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD1) e0_q <= src_rdata;
  end

  // output beat
  assign out_o.valid  = out_valid_q;
  assign out_o.result = sum_acc_q;

  // checks
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN1)
    else $error("result raised outside the final read");

  a_scr_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scr_we |-> $past(state_q) == S_MUL || $past(state_q) == S_CAP)
    else $error("scratch written outside a fold step");

endmodule
